// ===== hdl/threshold_spot_centroid_defines.svh =====
`ifndef THRESHOLD_SPOT_CENTROID_DEFINES_SVH
`define THRESHOLD_SPOT_CENTROID_DEFINES_SVH

// implication checked on the same edge
`define TSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// implication checked on the next edge
`define TSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/tsc_pkg.sv =====
`timescale 1ns / 1ps

package tsc_pkg;

  localparam int HIT_W = 23;
  localparam int COORD_W = 11;
  localparam int PIX_W = 8;
  localparam int GRAY_ACC_W = 22;
  localparam int GRAY_SHIFT = 14;

  localparam logic [13:0] GRAY_W_FIRST = 14'd4899;
  localparam logic [13:0] GRAY_W_SECOND = 14'd9617;
  localparam logic [13:0] GRAY_W_THIRD = 14'd1868;
  localparam logic [GRAY_ACC_W-1:0] GRAY_ROUND = GRAY_ACC_W'(8192);

  localparam logic [PIX_W-1:0] THRESH_RESET = 8'd229;

  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FIN  = 3'b100
  } div_state_t;

endpackage

// ===== hdl/threshold_spot_centroid.sv =====
`timescale 1ns / 1ps
// channel  dir  handshake             beat
// in_      in   in_valid/in_ready     one pixel: three channels, line and frame marks
// out_     out  out_valid/out_ready   one frame result: found flag, mean column and row
// cfg_     in   cfg_valid/cfg_ready   brightness threshold, 8 bits
// pixels are taken one per cycle while in_ready is high, through a two-stage front
// (gray and compare, then sums); after end of frame a frame result is computed by the
// one-bit-per-cycle restoring divider
// a two-entry frame queue sits between front and divider
// in_ready drops only when an end-of-frame pixel meets a full queue; cfg_ready is always high
// synchronous active-low reset clears counters and sums and sets the threshold to 229

module threshold_spot_centroid import tsc_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [PIX_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PIX_W-1:0]   in_channel_first,
  input  logic [PIX_W-1:0]   in_channel_second,
  input  logic [PIX_W-1:0]   in_channel_third,
  input  logic               in_end_of_line,
  input  logic               in_end_of_frame,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_spot_found,
  output logic [COORD_W-1:0] out_spot_x,
  output logic [COORD_W-1:0] out_spot_y
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int XSW = HIT_W + CW;
  localparam int YSW = HIT_W + RW;
  localparam int RECW = HIT_W + XSW + YSW;

  logic             f_valid, f_ready, b_valid, b_ready;
  logic [HIT_W-1:0] f_hits, b_hits;
  logic [XSW-1:0]   f_xsum, b_xsum;
  logic [YSW-1:0]   f_ysum, b_ysum;
  logic [RECW-1:0]  q_rd_data;

  assign cfg_ready = 1'b1;

  tsc_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_channel_first (in_channel_first),
    .in_channel_second(in_channel_second),
    .in_channel_third (in_channel_third),
    .in_end_of_line   (in_end_of_line),
    .in_end_of_frame  (in_end_of_frame),
    .rec_valid        (f_valid),
    .rec_ready        (f_ready),
    .rec_hits         (f_hits),
    .rec_xsum         (f_xsum),
    .rec_ysum         (f_ysum)
  );

  tsc_fifo #(
    .W(RECW)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(f_valid),
    .wr_ready(f_ready),
    .wr_data ({f_hits, f_xsum, f_ysum}),
    .rd_valid(b_valid),
    .rd_ready(b_ready),
    .rd_data (q_rd_data)
  );

  assign {b_hits, b_xsum, b_ysum} = q_rd_data;

  tsc_back #(
    .XSW(XSW),
    .YSW(YSW)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .rec_valid     (b_valid),
    .rec_ready     (b_ready),
    .rec_hits      (b_hits),
    .rec_xsum      (b_xsum),
    .rec_ysum      (b_ysum),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_spot_found(out_spot_found),
    .out_spot_x    (out_spot_x),
    .out_spot_y    (out_spot_y)
  );

endmodule

// ===== hdl/tsc_front.sv =====
`timescale 1ns / 1ps
`include "threshold_spot_centroid_defines.svh"

module tsc_front import tsc_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_HEIGHT = 2048,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT),
  localparam int XSW = HIT_W + CW,
  localparam int YSW = HIT_W + RW
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic [PIX_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] in_channel_first,
  input  logic [PIX_W-1:0] in_channel_second,
  input  logic [PIX_W-1:0] in_channel_third,
  input  logic             in_end_of_line,
  input  logic             in_end_of_frame,
  output logic             rec_valid,
  input  logic             rec_ready,
  output logic [HIT_W-1:0] rec_hits,
  output logic [XSW-1:0]   rec_xsum,
  output logic [YSW-1:0]   rec_ysum
);

  logic [PIX_W-1:0]      thresh_r, thresh_nxt;
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_hit_r, s1_eol_r, s1_eof_r;
  logic [CW-1:0]         col_r, col_nxt;
  logic [RW-1:0]         row_r, row_nxt;
  logic [HIT_W-1:0]      hits_r, hits_nxt;
  logic [XSW-1:0]        xsum_r, xsum_nxt;
  logic [YSW-1:0]        ysum_r, ysum_nxt;
  logic [GRAY_ACC_W-1:0] gray_acc;
  logic [PIX_W-1:0]      gray;
  logic                  accept, adv, take;

  assign gray_acc = GRAY_ACC_W'(in_channel_first) * GRAY_ACC_W'(GRAY_W_FIRST)
                  + GRAY_ACC_W'(in_channel_second) * GRAY_ACC_W'(GRAY_W_SECOND)
                  + GRAY_ACC_W'(in_channel_third) * GRAY_ACC_W'(GRAY_W_THIRD)
                  + GRAY_ROUND;
  assign gray = gray_acc[GRAY_SHIFT +: PIX_W];

  assign adv = s1_valid_r && (!s1_eof_r || rec_ready);
  assign in_ready = !s1_valid_r || adv;
  assign accept = in_valid && in_ready;

  assign take = s1_hit_r && (hits_r != {HIT_W{1'b1}});

  assign rec_valid = s1_valid_r && s1_eof_r;
  assign rec_hits = take ? hits_r + HIT_W'(1) : hits_r;
  assign rec_xsum = take ? xsum_r + XSW'(col_r) : xsum_r;
  assign rec_ysum = take ? ysum_r + YSW'(row_r) : ysum_r;

  always_comb begin
    thresh_nxt = cfg_valid ? cfg_data : thresh_r;
    s1_valid_nxt = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    col_nxt = col_r;
    row_nxt = row_r;
    hits_nxt = hits_r;
    xsum_nxt = xsum_r;
    ysum_nxt = ysum_r;
    if (adv) begin
      if (s1_eof_r) begin
        col_nxt = '0;
        row_nxt = '0;
        hits_nxt = '0;
        xsum_nxt = '0;
        ysum_nxt = '0;
      end else begin
        hits_nxt = rec_hits;
        xsum_nxt = rec_xsum;
        ysum_nxt = rec_ysum;
        if (s1_eol_r) begin
          col_nxt = '0;
          if (row_r < RW'(MAX_HEIGHT - 1)) row_nxt = row_r + RW'(1);
        end else if (col_r < CW'(MAX_WIDTH - 1)) begin
          col_nxt = col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
      s1_valid_r <= 1'b0;
      col_r <= '0;
      row_r <= '0;
      hits_r <= '0;
      xsum_r <= '0;
      ysum_r <= '0;
    end else begin
      thresh_r <= thresh_nxt;
      s1_valid_r <= s1_valid_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      hits_r <= hits_nxt;
      xsum_r <= xsum_nxt;
      ysum_r <= ysum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit_r <= gray > thresh_r;
      s1_eol_r <= in_end_of_line;
      s1_eof_r <= in_end_of_frame;
    end
  end

  `TSC_ASSERT_NEXT(a_frame_clear, adv && s1_eof_r,
    col_r == '0 && row_r == '0 && hits_r == '0 && xsum_r == '0 && ysum_r == '0,
    "frame state not cleared after end of frame")

endmodule

// ===== hdl/tsc_fifo.sv =====
`timescale 1ns / 1ps
`include "threshold_spot_centroid_defines.svh"

module tsc_fifo import tsc_pkg::*; #(
  parameter int W = 91
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CNTW = $clog2(QDEPTH + 1);

  logic [W-1:0]    mem_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            push, pop;

  assign wr_ready = cnt_r != CNTW'(QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data = mem_r[rd_ptr_r];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + CNTW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CNTW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  `TSC_ASSERT_NOW(a_fill_bound, 1'b1, cnt_r <= CNTW'(QDEPTH),
    "frame queue fill beyond depth")

endmodule

// ===== hdl/tsc_back.sv =====
`timescale 1ns / 1ps
`include "threshold_spot_centroid_defines.svh"

module tsc_back import tsc_pkg::*; #(
  parameter int XSW = 34,
  parameter int YSW = 34,
  localparam int SW = (XSW > YSW) ? XSW : YSW,
  localparam int CNTW = $clog2(SW + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rec_valid,
  output logic               rec_ready,
  input  logic [HIT_W-1:0]   rec_hits,
  input  logic [XSW-1:0]     rec_xsum,
  input  logic [YSW-1:0]     rec_ysum,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_spot_found,
  output logic [COORD_W-1:0] out_spot_x,
  output logic [COORD_W-1:0] out_spot_y
);

  div_state_t         state_r, state_nxt;
  logic [CNTW-1:0]    cnt_r, cnt_nxt;
  logic [HIT_W-1:0]   div_r, div_nxt;
  logic [SW-1:0]      dx_r, dx_nxt, dy_r, dy_nxt;
  logic [HIT_W-1:0]   rx_r, rx_nxt, ry_r, ry_nxt;
  logic               found_r, found_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r;
  logic [COORD_W-1:0] out_x_r, out_y_r;
  logic [HIT_W:0]     tx, ty;
  logic               gex, gey, pop, load_out;

  assign rec_ready = state_r == S_IDLE;
  assign pop = rec_valid && rec_ready;
  assign load_out = (state_r == S_FIN) && (!out_valid_r || out_ready);

  assign tx = {rx_r, dx_r[SW-1]};
  assign ty = {ry_r, dy_r[SW-1]};
  assign gex = tx >= {1'b0, div_r};
  assign gey = ty >= {1'b0, div_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    div_nxt = div_r;
    dx_nxt = dx_r;
    dy_nxt = dy_r;
    rx_nxt = rx_r;
    ry_nxt = ry_r;
    found_nxt = found_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (pop) begin
          found_nxt = rec_hits != '0;
          div_nxt = rec_hits;
          rx_nxt = '0;
          ry_nxt = '0;
          cnt_nxt = CNTW'(SW);
          if (rec_hits != '0) begin
            dx_nxt = SW'(rec_xsum);
            dy_nxt = SW'(rec_ysum);
            state_nxt = S_DIV;
          end else begin
            dx_nxt = '0;
            dy_nxt = '0;
            state_nxt = S_FIN;
          end
        end
      end
      S_DIV: begin
        rx_nxt = gex ? HIT_W'(tx - {1'b0, div_r}) : tx[HIT_W-1:0];
        ry_nxt = gey ? HIT_W'(ty - {1'b0, div_r}) : ty[HIT_W-1:0];
        dx_nxt = {dx_r[SW-2:0], gex};
        dy_nxt = {dy_r[SW-2:0], gey};
        cnt_nxt = cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    div_r <= div_nxt;
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    rx_r <= rx_nxt;
    ry_r <= ry_nxt;
    found_r <= found_nxt;
    if (load_out) begin
      out_found_r <= found_r;
      out_x_r <= dx_r[COORD_W-1:0];
      out_y_r <= dy_r[COORD_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_spot_found = out_found_r;
  assign out_spot_x = out_x_r;
  assign out_spot_y = out_y_r;

  `TSC_ASSERT_NOW(a_rem_below_div, state_r == S_DIV,
    rx_r < div_r && ry_r < div_r, "partial remainder not below divisor")
  `TSC_ASSERT_NOW(a_empty_zero, out_valid_r && !out_found_r,
    out_x_r == '0 && out_y_r == '0, "empty frame with nonzero centroid")

endmodule
